>>> src/dht_pkg.sv
// shared types and codes for the double-hashing table
// no dependencies; imported by the controller, datapath and top level
package dht_pkg;

    localparam int OP_BITS     = 2;
    localparam int RESULT_BITS = 3;
    localparam int STATE_BITS  = 2;

    // request codes; the unused code behaves as a find
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FIND   = 2'd2;

    typedef enum logic [RESULT_BITS-1:0] {
        RES_INSERTED  = 3'd0,
        RES_UPDATED   = 3'd1,
        RES_REMOVED   = 3'd2,
        RES_FOUND     = 3'd3,
        RES_NOT_FOUND = 3'd4,
        RES_FULL      = 3'd5
    } dht_result_t;

    typedef enum logic [STATE_BITS-1:0] {
        SLOT_EMPTY    = 2'd0,
        SLOT_OCCUPIED = 2'd1,
        SLOT_DELETED  = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_COMMIT
    } dht_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write one empty slot of the clearing pass
        logic load;    // capture the request word
        logic hash;    // one remainder stage
        logic probe;   // issue / check probe reads
        logic commit;  // update table and load the result word
    } dht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic hash_last;
        logic probe_done;
        logic out_free;
    } dht_status_t;

endpackage

>>> src/double_hash_table.sv
// flow: each request is accepted, its key is reduced to key mod N and key mod N-1 by
// reciprocal multiply, P probe reads are issued and checked, then the commit waits for a free result register
// throughput: one request at a time, so the next is taken only once the last commits;
// P is up to TABLE_SLOTS, and the single read port of the slot ram gives one probe per cycle
// reset: synchronous, active low; afterwards a clearing pass marks every slot empty,
// and no request is taken during it
module double_hash_table #(
    parameter int TABLE_SLOTS = 31,
    parameter int KEY_BITS    = 31,
    parameter int DATA_BITS   = 32
) (
    input  logic aclk,
    input  logic aresetn,

    // request word; tdata from lsb: operation, key, data, zero pad
    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    input  logic [((dht_pkg::OP_BITS + KEY_BITS + DATA_BITS + 7) / 8) * 8 - 1:0]
                                                             s_axis_tdata,

    // result word; tdata from lsb: status, found_data, slot_index, record_count, zero pad
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    output logic [((dht_pkg::RESULT_BITS + DATA_BITS + $clog2(TABLE_SLOTS)
                    + $clog2(TABLE_SLOTS + 1) + 7) / 8) * 8 - 1:0]
                                                             m_axis_tdata
);
    import dht_pkg::*;

    localparam int SB       = $clog2(TABLE_SLOTS);
    localparam int CB       = $clog2(TABLE_SLOTS + 1);
    localparam int OUT_BITS = RESULT_BITS + DATA_BITS + SB + CB;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // unpacked request fields
    logic [OP_BITS-1:0]          s_operation;
    logic [KEY_BITS-1:0]         s_key;
    logic signed [DATA_BITS-1:0] s_data;

    // result fields from the datapath's output register
    logic [RESULT_BITS-1:0]      m_status;
    logic signed [DATA_BITS-1:0] m_found_data;
    logic [SB-1:0]               m_slot_index;
    logic [CB-1:0]               m_record_count;

    dht_cmd_t    cmd;
    dht_status_t status;

    assign s_operation = s_axis_tdata[OP_BITS-1:0];
    assign s_key       = s_axis_tdata[OP_BITS+KEY_BITS-1:OP_BITS];
    assign s_data      = s_axis_tdata[OP_BITS+KEY_BITS+DATA_BITS-1:OP_BITS+KEY_BITS];

    // controller: clearing pass, accept, hash, probe, commit
    dht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: holds the slot ram, the record count and the result register,
    // so a finished result can wait while the next request is accepted
    dht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_operation    (s_operation),
        .s_key          (s_key),
        .s_data         (s_data),
        .m_ready        (m_axis_tready),
        .m_valid        (m_axis_tvalid),
        .m_status       (m_status),
        .m_found_data   (m_found_data),
        .m_slot_index   (m_slot_index),
        .m_record_count (m_record_count)
    );

    // pack result fields, zero-extended to whole bytes
    assign m_axis_tdata = OUT_W'({m_record_count, m_slot_index, m_found_data, m_status});

endmodule

>>> src/dht_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/dht_ctrl.sv
// controller state machine for the hash table
// depends on dht_pkg
module dht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dht_pkg::dht_status_t status,
    output dht_pkg::dht_cmd_t    cmd
);
    import dht_pkg::*;

    dht_state_t state_reg;
    dht_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_HASH;
            end
            ST_HASH: begin
                if (status.hash_last) state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (status.probe_done) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_HASH:   cmd.hash   = 1'b1;
            ST_PROBE:  cmd.probe  = 1'b1;
            ST_COMMIT: cmd.commit = status.out_free;
            default:   cmd = '0;
        endcase
    end

    // a request is taken only once until its result is committed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted twice in a row");

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(cmd))
        else $error("more than one datapath command");

endmodule

>>> src/dht_datapath.sv
// datapath: request registers, reciprocal remainder unit, probe pipeline, slot ram
// and result register; depends on dht_pkg and dht_ram
module dht_datapath #(
    parameter int TABLE_SLOTS = 31,
    parameter int KEY_BITS    = 31,
    parameter int DATA_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dht_pkg::dht_cmd_t                   cmd,
    output dht_pkg::dht_status_t                status,
    input  logic [dht_pkg::OP_BITS-1:0]         s_operation,
    input  logic [KEY_BITS-1:0]                 s_key,
    input  logic signed [DATA_BITS-1:0]         s_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [dht_pkg::RESULT_BITS-1:0]     m_status,
    output logic signed [DATA_BITS-1:0]         m_found_data,
    output logic [$clog2(TABLE_SLOTS)-1:0]      m_slot_index,
    output logic [$clog2(TABLE_SLOTS+1)-1:0]    m_record_count
);
    import dht_pkg::*;

    localparam int SB         = $clog2(TABLE_SLOTS);
    localparam int CB         = $clog2(TABLE_SLOTS + 1);
    localparam int ENTRY_BITS = DATA_BITS + KEY_BITS + STATE_BITS;
    localparam logic [SB:0]   SLOTS_W  = (SB + 1)'(TABLE_SLOTS);
    localparam logic [CB-1:0] SLOTS_C  = CB'(TABLE_SLOTS);

    // reciprocals ceil(2^(KEY_BITS+L)/d), exact quotient for every key
    localparam int LA = $clog2(TABLE_SLOTS);
    localparam int LB = $clog2(TABLE_SLOTS - 1);
    localparam int QA = KEY_BITS - LA + 1;
    localparam int QB = KEY_BITS - LB + 1;
    localparam int PW = 2 * KEY_BITS + 1;
    localparam logic [127:0] POW_A = 128'd1 << (KEY_BITS + LA);
    localparam logic [127:0] POW_B = 128'd1 << (KEY_BITS + LB);
    localparam logic [KEY_BITS:0] RCP_A =
        (KEY_BITS + 1)'((POW_A + 128'(TABLE_SLOTS - 1)) / 128'(TABLE_SLOTS));
    localparam logic [KEY_BITS:0] RCP_B =
        (KEY_BITS + 1)'((POW_B + 128'(TABLE_SLOTS - 2)) / 128'(TABLE_SLOTS - 1));

    // request
    logic [OP_BITS-1:0]         op_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic signed [DATA_BITS-1:0] data_reg;

    // remainder unit
    logic                hash_ph_reg;
    logic [QA-1:0]       quot_a_reg;
    logic [QB-1:0]       quot_b_reg;
    logic [PW-1:0]       prod_a, prod_b;
    logic [KEY_BITS-1:0] diff_a, diff_b;
    logic [SB-1:0]       ra_next, rb_next;
    logic                hash_last;

    // probe pipeline
    logic [SB-1:0] idx_reg;
    logic [SB-1:0] step_reg;
    logic [CB-1:0] issue_cnt_reg;
    logic          chk_valid_reg;
    logic          chk_last_reg;
    logic [SB-1:0] chk_addr_reg;
    logic [SB:0]   idx_sum, idx_wrap;
    logic          issuing;

    // probe outcome
    logic          hit_found_reg;
    logic [SB-1:0] hit_slot_reg;
    logic signed [DATA_BITS-1:0] hit_data_reg;
    logic          free_found_reg;
    logic [SB-1:0] free_slot_reg;

    // slot ram
    logic [ENTRY_BITS-1:0] ram_q;
    logic [ENTRY_BITS-1:0] ram_wr_data;
    logic [SB-1:0]         ram_wr_addr;
    logic                  ram_wr_en;
    slot_state_t           q_state;
    logic [KEY_BITS-1:0]   q_key;
    logic                  q_hit, q_empty, q_free, chk_on;

    // clearing pass and bookkeeping
    logic [SB-1:0] clear_addr_reg;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;

    // commit decision
    logic          commit_wr;
    logic [SB-1:0] commit_slot;
    slot_state_t   commit_state;
    dht_result_t   commit_res;
    logic [SB-1:0] commit_out_slot;
    logic signed [DATA_BITS-1:0] commit_out_data;

    // result register
    logic                        m_valid_reg;
    dht_result_t                 m_status_reg;
    logic signed [DATA_BITS-1:0] m_found_data_reg;
    logic [SB-1:0]               m_slot_reg;
    logic [CB-1:0]               m_count_reg;

    // first stage: quotients by reciprocal multiply; second stage: key - q*d
    always_comb begin
        prod_a    = PW'(key_reg) * PW'(RCP_A);
        prod_b    = PW'(key_reg) * PW'(RCP_B);
        diff_a    = key_reg - KEY_BITS'(quot_a_reg) * KEY_BITS'(TABLE_SLOTS);
        diff_b    = key_reg - KEY_BITS'(quot_b_reg) * KEY_BITS'(TABLE_SLOTS - 1);
        ra_next   = diff_a[SB-1:0];
        rb_next   = diff_b[SB-1:0];
        hash_last = hash_ph_reg;
    end

    always_comb begin
        idx_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
        idx_wrap = (idx_sum >= SLOTS_W) ? (idx_sum - SLOTS_W) : idx_sum;
        issuing  = cmd.probe && (issue_cnt_reg != SLOTS_C);
    end

    always_comb begin
        q_state = slot_state_t'(ram_q[STATE_BITS-1:0]);
        q_key   = ram_q[KEY_BITS+STATE_BITS-1:STATE_BITS];
        q_hit   = (q_state == SLOT_OCCUPIED) && (q_key == key_reg);
        q_empty = (q_state == SLOT_EMPTY);
        q_free  = (q_state != SLOT_OCCUPIED);
        chk_on  = cmd.probe && chk_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_operation;
            key_reg     <= s_key;
            data_reg    <= s_data;
            hash_ph_reg <= 1'b0;
        end else if (cmd.hash) begin
            hash_ph_reg <= 1'b1;
            quot_a_reg  <= prod_a[PW-1:KEY_BITS+LA];
            quot_b_reg  <= prod_b[PW-1:KEY_BITS+LB];
        end
    end

    // probe addresses advance every cycle while reads are issued; a read's slot is checked in the next cycle
    always_ff @(posedge aclk) begin
        if (cmd.hash && hash_last) begin
            idx_reg        <= ra_next;
            step_reg       <= rb_next + 1'b1;
            issue_cnt_reg  <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (issuing) begin
                idx_reg       <= idx_wrap[SB-1:0];
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (chk_on && q_hit) begin
                hit_found_reg <= 1'b1;
                hit_slot_reg  <= chk_addr_reg;
                hit_data_reg  <= ram_q[ENTRY_BITS-1:KEY_BITS+STATE_BITS];
            end
            if (chk_on && q_free && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= chk_addr_reg;
            end
        end
        chk_addr_reg <= idx_reg;
        chk_last_reg <= (issue_cnt_reg == CB'(TABLE_SLOTS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= issuing;
        end
    end

    always_comb begin
        commit_wr       = 1'b0;
        commit_slot     = hit_slot_reg;
        commit_state    = SLOT_OCCUPIED;
        commit_res      = RES_NOT_FOUND;
        commit_out_slot = '0;
        commit_out_data = '0;
        count_next      = count_reg;
        priority if (op_reg == OP_INSERT) begin
            if (hit_found_reg) begin
                commit_wr       = 1'b1;
                commit_res      = RES_UPDATED;
                commit_out_slot = hit_slot_reg;
            end else if ((count_reg < SLOTS_C) && free_found_reg) begin
                commit_wr       = 1'b1;
                commit_slot     = free_slot_reg;
                commit_res      = RES_INSERTED;
                commit_out_slot = free_slot_reg;
                count_next      = count_reg + 1'b1;
            end else begin
                commit_res = RES_FULL;
            end
        end else if (op_reg == OP_REMOVE) begin
            if (hit_found_reg) begin
                commit_wr       = 1'b1;
                commit_state    = SLOT_DELETED;
                commit_res      = RES_REMOVED;
                commit_out_slot = hit_slot_reg;
                if (count_reg != '0) count_next = count_reg - 1'b1;
            end
        end else begin
            if (hit_found_reg) begin
                commit_res      = RES_FOUND;
                commit_out_slot = hit_slot_reg;
                commit_out_data = hit_data_reg;
            end
        end
    end

    always_comb begin
        ram_wr_en   = cmd.clear || (cmd.commit && commit_wr);
        ram_wr_addr = cmd.clear ? clear_addr_reg : commit_slot;
        ram_wr_data = cmd.clear ? {{(DATA_BITS + KEY_BITS){1'b0}}, SLOT_EMPTY}
                                : {data_reg, key_reg, commit_state};
    end

    dht_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issuing),
        .rd_addr (idx_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_addr_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clear && !status.clear_done) begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (cmd.commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg     <= commit_res;
            m_found_data_reg <= commit_out_data;
            m_slot_reg       <= commit_out_slot;
            m_count_reg      <= count_next;
        end
    end

    always_comb begin
        status.clear_done = (clear_addr_reg == SB'(TABLE_SLOTS - 1));
        status.hash_last  = hash_last;
        status.probe_done = chk_valid_reg && (q_hit || q_empty || chk_last_reg);
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_found_data   = m_found_data_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_record_count = m_count_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= SLOTS_C)
        else $error("record count above table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(cmd.commit))
        else $error("record count moved outside a commit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |-> ({1'b0, idx_reg} < SLOTS_W))
        else $error("probe index out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

endmodule

>>> bench/testbench.sv
// self-checking bench for the double_hash_table request/result streams
// depends on dht_pkg and double_hash_table; keeps a mirror of the 31-slot table
// to predict each result word, then compares every result word field by field
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dht_pkg::*;

    localparam int TABLE_N   = 31;
    localparam int KEY_W     = 31;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 72;
    localparam int RES_W     = 48;
    localparam int POOL_N    = 40;
    localparam int PHASE_LEN = 470;
    localparam int STALL_MAX = 2000;
    localparam int DRAIN_CYC = 80;

    // unused request code, handled as a lookup
    localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

    // result word fields from the lsb: status, found_data, slot_index, record_count
    typedef struct packed {
        logic [4:0]        count;
        logic [4:0]        slot;
        logic [DATA_W-1:0] found;
        dht_result_t       status;
    } reply_t;

    // mirror of the slot table; predicts one reply per accepted request
    class table_mirror;
        slot_state_t       slot_state[TABLE_N];
        logic [KEY_W-1:0]  slot_key[TABLE_N];
        logic [DATA_W-1:0] slot_data[TABLE_N];
        int unsigned       occupied;
        reply_t            awaited[$];
        int unsigned       errors;

        function new();
            foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
            occupied = 0;
            errors   = 0;
        endfunction

        // walk the double-hash sequence; either first free slot or the matching key
        function bit walk(input logic [KEY_W-1:0] key, input bit want_free,
                          output int unsigned hit);
            int unsigned idx;
            int unsigned step;
            idx  = key % TABLE_N;
            step = 1 + key % (TABLE_N - 1);
            hit  = 0;
            for (int a = 0; a < TABLE_N; a++) begin
                if (want_free) begin
                    if (slot_state[idx] != SLOT_OCCUPIED) begin
                        hit = idx;
                        return 1'b1;
                    end
                end else begin
                    if (slot_state[idx] == SLOT_EMPTY)
                        return 1'b0;
                    if (slot_state[idx] == SLOT_OCCUPIED && slot_key[idx] == key) begin
                        hit = idx;
                        return 1'b1;
                    end
                end
                idx = (idx + step) % TABLE_N;
            end
            return 1'b0;
        endfunction

        function void note_request(input logic [OP_BITS-1:0] op,
                                   input logic [KEY_W-1:0] key,
                                   input logic [DATA_W-1:0] data);
            reply_t      r;
            int unsigned hit;
            r = '{count: '0, slot: '0, found: '0, status: RES_NOT_FOUND};
            case (op)
                OP_INSERT: begin
                    if (walk(key, 1'b0, hit)) begin
                        slot_data[hit] = data;
                        r.status = RES_UPDATED;
                        r.slot   = hit[4:0];
                    end else if (occupied < TABLE_N && walk(key, 1'b1, hit)) begin
                        slot_key[hit]   = key;
                        slot_data[hit]  = data;
                        slot_state[hit] = SLOT_OCCUPIED;
                        occupied++;
                        r.status = RES_INSERTED;
                        r.slot   = hit[4:0];
                    end else begin
                        r.status = RES_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (walk(key, 1'b0, hit)) begin
                        slot_state[hit] = SLOT_DELETED;
                        if (occupied > 0) occupied--;
                        r.status = RES_REMOVED;
                        r.slot   = hit[4:0];
                    end
                end
                default: begin
                    if (walk(key, 1'b0, hit)) begin
                        r.status = RES_FOUND;
                        r.found  = slot_data[hit];
                        r.slot   = hit[4:0];
                    end
                end
            endcase
            r.count = occupied[4:0];
            awaited.push_back(r);
        endfunction

        function void check_result(input logic [RES_W-1:0] word);
            reply_t got;
            reply_t want;
            got = word[$bits(reply_t)-1:0];
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, word);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.found != want.found) begin
                $display("%0t: found_data expected %h got %h", $time, want.found, got.found);
                errors++;
            end
            if (got.slot != want.slot) begin
                $display("%0t: slot_index expected %0d got %0d", $time, want.slot, got.slot);
                errors++;
            end
            if (got.count != want.count) begin
                $display("%0t: record_count expected %0d got %0d", $time, want.count,
                         got.count);
                errors++;
            end
        endfunction
    endclass

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [REQ_W-1:0] s_axis_tdata  = '0;   // from lsb: operation, key, data, zero pad
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [RES_W-1:0] m_axis_tdata;         // from lsb: status, found_data, slot, count, pad

    table_mirror      book = new();
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      quiet_cycles   = 0;
    logic [KEY_W-1:0] key_pool[POOL_N];

    double_hash_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    // receiver: stall at random, decided at the falling edge
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every result word taken at the rising edge is checked against the oldest prediction
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata);
    end

    // watchdog: a long run of cycles without any word moving means a hang
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("double_hash_table regression: fail");
            $finish;
        end
    end

    // one request word; idles at random first, then holds the word until taken
    task automatic send_request(input logic [OP_BITS-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(REQ_W - OP_BITS - KEY_W - DATA_W){1'b0}}, data, key, op};
        do @(posedge aclk); while (!s_axis_tready);
        book.note_request(op, key, data);
    endtask

    // keys for one phase: plain random, colliding on home slot 0..2, and near the top
    function automatic void fill_pool();
        foreach (key_pool[i]) begin
            case (i % 3)
                0: key_pool[i] = KEY_W'($urandom);
                1: key_pool[i] = KEY_W'($urandom_range(0, 40) * TABLE_N + $urandom_range(0, 2));
                default: key_pool[i] = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 200));
            endcase
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned          r;
        logic [OP_BITS-1:0]   op;
        int unsigned          sends[4];
        int unsigned          stalls[4];
        sends  = '{0, 46, 0, 33};
        stalls = '{0, 0, 46, 33};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, update, collisions, tombstones, spare code
        send_request(OP_FIND,   31'd0, 32'd0);             // lookup on an empty table
        send_request(OP_REMOVE, 31'd0, 32'd0);             // remove of an absent key
        send_request(OP_INSERT, 31'd0, 32'h7fff_ffff);
        send_request(OP_INSERT, 31'd0, 32'h8000_0000);     // update in place
        send_request(OP_FIND,   31'd0, 32'hffff_ffff);
        send_request(OP_INSERT, 31'h7fff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 31'd31, 32'd0);            // same home slot as key 0
        send_request(OP_INSERT, 31'd62, 32'h5555_5555);    // third key on that home slot
        send_request(OP_SPARE,  31'd31, 32'h1234_5678);    // spare code acts as a lookup
        send_request(OP_REMOVE, 31'd0, 32'd0);             // leaves a tombstone at slot 0
        send_request(OP_FIND,   31'd31, 32'd0);            // probes past the tombstone
        send_request(OP_FIND,   31'd0, 32'd0);             // removed key is gone
        send_request(OP_INSERT, 31'd93, 32'haaaa_aaaa);    // reuses the tombstone
        send_request(OP_FIND,   31'h7fff_ffff, 32'd0);
        send_request(OP_SPARE,  31'h2aaa_aaaa, 32'd0);     // spare code, absent key
        send_request(OP_INSERT, 31'h5555_5555, 32'h5555_5555);
        send_request(OP_INSERT, 31'h2aaa_aaaa, 32'haaaa_aaaa);
        send_request(OP_REMOVE, 31'h7fff_ffff, 32'd0);
        send_request(OP_REMOVE, 31'd31, 32'd0);
        send_request(OP_REMOVE, 31'd31, 32'd0);            // second remove misses
        send_request(OP_FIND,   31'd62, 32'd0);

        // random phases; segments alternate between filling the table (full replies)
        // and draining it (tombstones, misses)
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = sends[ph];
            recv_stall_pct = stalls[ph];
            fill_pool();
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(99);
                if ((n / 60) % 2 == 0)
                    op = (r < 60) ? OP_INSERT : (r < 75) ? OP_REMOVE :
                         (r < 95) ? OP_FIND : OP_SPARE;
                else
                    op = (r < 25) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                         (r < 95) ? OP_FIND : OP_SPARE;
                if ($urandom_range(0, 9) == 0)
                    send_request(op, KEY_W'($urandom), pick_data());
                else
                    send_request(op, key_pool[$urandom_range(0, POOL_N - 1)], pick_data());
            end
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (book.awaited.size() != 0) @(posedge aclk);
        // stray words after the last expected one are flagged by the checker
        repeat (DRAIN_CYC) @(posedge aclk);

        if (book.errors == 0)
            $display("double_hash_table regression: pass");
        else
            $display("double_hash_table regression: fail");
        $finish;
    end
endmodule

>>> files.f
src/dht_pkg.sv
src/dht_ram.sv
src/dht_ctrl.sv
src/dht_datapath.sv
src/double_hash_table.sv
bench/testbench.sv
